### hw/rtl/ntcbt_pkg.sv
// ----------------------------------------------------------------------------
// ntcbt_pkg
// Shared widths, constants and types of the NTC beta-equation temperature block.
// ----------------------------------------------------------------------------
package ntcbt_pkg;

	localparam int ADC_BITS_DEF = 12;

	// configuration register widths
	localparam int DIV_W      = 20;
	localparam int NOM_W      = 20;
	localparam int T0_W       = 8;
	localparam int BETA_W     = 14;
	localparam int REF_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_DIVIDER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOMINAL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOM_TEMP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BETA      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 3'd4;

	localparam logic [DIV_W-1:0]  DIVIDER_RST   = 20'd9600;
	localparam logic [NOM_W-1:0]  NOMINAL_RST   = 20'd10000;
	localparam logic [T0_W-1:0]   NOM_TEMP_RST  = 8'd25;
	localparam logic [BETA_W-1:0] BETA_RST      = 14'd3950;
	localparam logic [REF_W-1:0]  REFERENCE_RST = 13'd3300;

	// front end
	localparam int VOUT_W = 12;
	localparam logic [VOUT_W-1:0] FULL_SCALE_MV = 12'd3300;
	localparam int RT_W = DIV_W + REF_W;

	// log2 in Q.30
	localparam int LOG_INT_W  = 6;
	localparam int LOG_FRAC_W = 30;
	localparam int MANT_W     = LOG_FRAC_W + 1;
	localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
	localparam int DIFF_W     = LOG_W + 1;

	localparam int LN2_W = 24;
	localparam logic [LN2_W-1:0] LN2_Q24 = 24'd11629080;
	localparam int MAG_HALF_W = LOG_W / 2;
	localparam int PROD_W = LOG_W + LN2_W;
	localparam int LN_SHIFT = 38;
	localparam int LN_MAG_W = PROD_W - LN_SHIFT;

	// second divider section: ln/B and 1/T0, both Q7.30
	localparam int Q30_NUM_W = 37;
	localparam int Q30_DEN_W = 16;
	localparam logic [Q30_NUM_W-1:0] INV_T0_SCALE = 37'(100) << LOG_FRAC_W;
	localparam logic [Q30_DEN_W-1:0] ZERO_C_CENTI_K = 16'd27315;
	localparam logic [Q30_DEN_W-1:0] CENTI = 16'd100;
	localparam int X_W = Q30_NUM_W + 1;

	// final reciprocal
	localparam int TMK_NUM_W = 41;
	localparam int TMK_DEN_W = Q30_NUM_W;
	localparam logic [TMK_NUM_W-1:0] TMK_SCALE = 41'(1000) << LOG_FRAC_W;

	localparam int TEMP_W = 20;
	localparam logic [TMK_NUM_W-1:0] TMK_HOT_LIMIT  = 41'd573150;
	localparam logic [TEMP_W-1:0]    ZERO_C_MILLI_K = 20'd273150;
	localparam logic [TEMP_W-1:0]    TEMP_LIMIT     = 20'd300000;

	typedef logic signed [TEMP_W-1:0] temp_t;

	typedef struct packed {
		logic [LOG_INT_W-1:0] k;
		logic [MANT_W-1:0]    x;
	} mant_t;

endpackage

### hw/rtl/ntcbt_div_pipe.sv
// ----------------------------------------------------------------------------
// ntcbt_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module ntcbt_div_pipe #(
	parameter int NUM_W  = 33,
	parameter int DEN_W  = 12,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [SIDE_W-1:0] out_side
);

	// numerator bits shift out of the top while quotient bits shift in
	logic              v_s    [NUM_W];
	logic [NUM_W-1:0]  nq_s   [NUM_W];
	logic [DEN_W-1:0]  rem_s  [NUM_W];
	logic [DEN_W-1:0]  den_s  [NUM_W];
	logic [SIDE_W-1:0] side_s [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic              cur_v;
		logic [NUM_W-1:0]  cur_nq;
		logic [DEN_W-1:0]  cur_rem;
		logic [DEN_W-1:0]  cur_den;
		logic [SIDE_W-1:0] cur_side;
		logic [DEN_W:0]    trial;
		logic              ge;

		if (i == 0) begin : g_first
			assign cur_v    = in_valid;
			assign cur_nq   = num;
			assign cur_rem  = '0;
			assign cur_den  = den;
			assign cur_side = side;
		end else begin : g_next
			assign cur_v    = v_s[i-1];
			assign cur_nq   = nq_s[i-1];
			assign cur_rem  = rem_s[i-1];
			assign cur_den  = den_s[i-1];
			assign cur_side = side_s[i-1];
		end

		assign trial = {cur_rem, cur_nq[NUM_W-1]};
		assign ge    = trial >= {1'b0, cur_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? DEN_W'(trial - {1'b0, cur_den}) : trial[DEN_W-1:0];
				nq_s[i]   <= {cur_nq[NUM_W-2:0], ge};
				den_s[i]  <= cur_den;
				side_s[i] <= cur_side;
			end
		end
	end

	assign out_valid = v_s[NUM_W-1];
	assign quo       = nq_s[NUM_W-1];
	assign out_side  = side_s[NUM_W-1];

endmodule

### hw/rtl/ntcbt_log2_diff.sv
// ----------------------------------------------------------------------------
// ntcbt_log2_diff
// Two-lane log2 pipeline in Q.30 by repeated squaring; outputs log2(a) - log2(b).
// ----------------------------------------------------------------------------
module ntcbt_log2_diff (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [ntcbt_pkg::RT_W-1:0]          a,
	input  logic [ntcbt_pkg::RT_W-1:0]          b,
	input  logic                                err_in,
	output logic                                out_valid,
	output logic signed [ntcbt_pkg::DIFF_W-1:0] diff,
	output logic                                err_out
);
	import ntcbt_pkg::*;

	function automatic mant_t normalize(input logic [RT_W-1:0] n);
		mant_t r;
		logic [RT_W+MANT_W-1:0] wide;
		r.k = '0;
		for (int i = 1; i < RT_W; i++) begin
			if (n[i]) r.k = LOG_INT_W'(i);
		end
		if (r.k >= LOG_INT_W'(LOG_FRAC_W)) begin
			wide = (RT_W+MANT_W)'(n) >> (r.k - LOG_INT_W'(LOG_FRAC_W));
		end else begin
			wide = (RT_W+MANT_W)'(n) << (LOG_INT_W'(LOG_FRAC_W) - r.k);
		end
		r.x = wide[MANT_W-1:0];
		return r;
	endfunction

	mant_t ma_s1, mb_s1;
	logic  v_s1, err_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= normalize(a);
			mb_s1  <= normalize(b);
			err_s1 <= err_in;
		end
	end

	// squaring stages, one fraction bit each
	logic                  v_s2   [LOG_FRAC_W];
	logic                  err_s2 [LOG_FRAC_W];
	logic [LOG_INT_W-1:0]  ka_s2  [LOG_FRAC_W];
	logic [LOG_INT_W-1:0]  kb_s2  [LOG_FRAC_W];
	logic [MANT_W-1:0]     xa_s2  [LOG_FRAC_W];
	logic [MANT_W-1:0]     xb_s2  [LOG_FRAC_W];
	logic [LOG_FRAC_W-1:0] fa_s2  [LOG_FRAC_W];
	logic [LOG_FRAC_W-1:0] fb_s2  [LOG_FRAC_W];

	for (genvar i = 0; i < LOG_FRAC_W; i++) begin : g_sq
		logic                  cur_v, cur_err;
		logic [LOG_INT_W-1:0]  cur_ka, cur_kb;
		logic [MANT_W-1:0]     cur_xa, cur_xb;
		logic [LOG_FRAC_W-1:0] cur_fa, cur_fb;
		logic [2*MANT_W-1:0]   pa, pb;
		logic [MANT_W:0]       ya, yb;

		if (i == 0) begin : g_first
			assign cur_v   = v_s1;
			assign cur_err = err_s1;
			assign cur_ka  = ma_s1.k;
			assign cur_kb  = mb_s1.k;
			assign cur_xa  = ma_s1.x;
			assign cur_xb  = mb_s1.x;
			assign cur_fa  = '0;
			assign cur_fb  = '0;
		end else begin : g_next
			assign cur_v   = v_s2[i-1];
			assign cur_err = err_s2[i-1];
			assign cur_ka  = ka_s2[i-1];
			assign cur_kb  = kb_s2[i-1];
			assign cur_xa  = xa_s2[i-1];
			assign cur_xb  = xb_s2[i-1];
			assign cur_fa  = fa_s2[i-1];
			assign cur_fb  = fb_s2[i-1];
		end

		assign pa = cur_xa * cur_xa;
		assign pb = cur_xb * cur_xb;
		assign ya = pa[LOG_FRAC_W +: MANT_W+1];
		assign yb = pb[LOG_FRAC_W +: MANT_W+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[i] <= 1'b0;
			end else if (en) begin
				v_s2[i] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				err_s2[i] <= cur_err;
				ka_s2[i]  <= cur_ka;
				kb_s2[i]  <= cur_kb;
				xa_s2[i]  <= ya[MANT_W] ? ya[MANT_W:1] : ya[MANT_W-1:0];
				xb_s2[i]  <= yb[MANT_W] ? yb[MANT_W:1] : yb[MANT_W-1:0];
				fa_s2[i]  <= {cur_fa[LOG_FRAC_W-2:0], ya[MANT_W]};
				fb_s2[i]  <= {cur_fb[LOG_FRAC_W-2:0], yb[MANT_W]};
			end
		end
	end

	logic [LOG_W-1:0] la, lb;
	logic             v_s3, err_s3;
	logic signed [DIFF_W-1:0] diff_s3;

	assign la = {ka_s2[LOG_FRAC_W-1], fa_s2[LOG_FRAC_W-1]};
	assign lb = {kb_s2[LOG_FRAC_W-1], fb_s2[LOG_FRAC_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2[LOG_FRAC_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s3 <= $signed({1'b0, la}) - $signed({1'b0, lb});
			err_s3  <= err_s2[LOG_FRAC_W-1];
		end
	end

	assign out_valid = v_s3;
	assign diff      = diff_s3;
	assign err_out   = err_s3;

endmodule

### hw/rtl/ntc_beta_temperature.sv
// ----------------------------------------------------------------------------
// ntc_beta_temperature
// NTC thermistor temperature from one converter sample by the beta equation.
// ----------------------------------------------------------------------------
// Takes one sample per cycle unless stalled, returning a temperature in
// milli-degrees C. It holds the long division stages, one quotient bit per
// stage (33 for the resistance, 37 for ln/B and 1/T0 side by side, 41 for the
// final reciprocal), and the 30 squaring stages of the log2 unit; the rest is
// eight single register stages. A stall at the output freezes the whole
// pipeline. range_error (temperature 0) flags a zero or uncomputable resistance
// or a zero nominal or beta register. The user must write registers through
// cfg_we/cfg_index/cfg_data only while the block is idle; it does not check this.
module ntc_beta_temperature #(
	parameter int ADC_BITS = ntcbt_pkg::ADC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ntcbt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ntcbt_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ADC_BITS-1:0]                 adc_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ntcbt_pkg::TEMP_W-1:0] temperature_milli_c,
	output logic                                range_error
);
	import ntcbt_pkg::*;

	logic [DIV_W-1:0]  divider_ohms_q;
	logic [NOM_W-1:0]  nominal_ohms_q;
	logic [T0_W-1:0]   nominal_temp_c_q;
	logic [BETA_W-1:0] beta_kelvin_q;
	logic [REF_W-1:0]  reference_mv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_ohms_q   <= DIVIDER_RST;
			nominal_ohms_q   <= NOMINAL_RST;
			nominal_temp_c_q <= NOM_TEMP_RST;
			beta_kelvin_q    <= BETA_RST;
			reference_mv_q   <= REFERENCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIVIDER:   divider_ohms_q   <= cfg_data[DIV_W-1:0];
				REG_NOMINAL:   nominal_ohms_q   <= cfg_data[NOM_W-1:0];
				REG_NOM_TEMP:  nominal_temp_c_q <= cfg_data[T0_W-1:0];
				REG_BETA:      beta_kelvin_q    <= cfg_data[BETA_W-1:0];
				REG_REFERENCE: reference_mv_q   <= cfg_data[REF_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless a finished result is held at the output and stalled
	logic adv;
	logic out_valid_q;
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// s1: scale to millivolts
	logic [ADC_BITS+VOUT_W-1:0] scaled;
	logic [VOUT_W-1:0]          vout_s1;
	logic                       v_s1;

	assign scaled = FULL_SCALE_MV * adc_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) vout_s1 <= scaled[ADC_BITS +: VOUT_W];
	end

	// s2: range check and resistance numerator
	logic [REF_W-1:0]  drop;
	logic [RT_W-1:0]   rt_num_s2;
	logic [VOUT_W-1:0] vout_s2;
	logic              err_s2, v_s2;

	assign drop = reference_mv_q - REF_W'(vout_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rt_num_s2 <= divider_ohms_q * drop;
			vout_s2   <= vout_s1;
			err_s2    <= (vout_s1 == '0) || (REF_W'(vout_s1) >= reference_mv_q)
				|| (nominal_ohms_q == '0) || (beta_kelvin_q == '0);
		end
	end

	logic            rt_valid, rt_err;
	logic [RT_W-1:0] rt;

	ntcbt_div_pipe #(.NUM_W(RT_W), .DEN_W(VOUT_W), .SIDE_W(1)) u_rt_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s2),
		.num      (rt_num_s2),
		.den      (vout_s2),
		.side     (err_s2),
		.out_valid(rt_valid),
		.quo      (rt),
		.out_side (rt_err)
	);

	logic                     log_valid, log_err;
	logic signed [DIFF_W-1:0] log_diff;

	ntcbt_log2_diff u_log (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (rt_valid),
		.a        (RT_W'(nominal_ohms_q)),
		.b        (rt),
		.err_in   (rt_err || (rt == '0)),
		.out_valid(log_valid),
		.diff     (log_diff),
		.err_out  (log_err)
	);

	// s4: magnitude times ln2, split in two partial products
	logic [DIFF_W-1:0]         mag_full;
	logic [LOG_W-1:0]          mag;
	logic [MAG_HALF_W+LN2_W-1:0] plo_s4, phi_s4;
	logic                      neg_s4, err_s4, v_s4;

	assign mag_full = log_diff[DIFF_W-1] ? DIFF_W'(-log_diff) : DIFF_W'(log_diff);
	assign mag      = mag_full[LOG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= log_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			plo_s4 <= mag[MAG_HALF_W-1:0] * LN2_Q24;
			phi_s4 <= mag[LOG_W-1:MAG_HALF_W] * LN2_Q24;
			neg_s4 <= log_diff[DIFF_W-1];
			err_s4 <= log_err;
		end
	end

	// s5: round ln to Q6.16, build the two Q7.30 numerators
	logic [PROD_W-1:0]    prod, prod_rnd;
	logic [LN_MAG_W-1:0]  ln_mag;
	logic [Q30_DEN_W-1:0] t0_ck;
	logic [Q30_NUM_W-1:0] ln_num_s5, inv_num_s5;
	logic [Q30_DEN_W-1:0] beta_s5, t0_s5;
	logic                 neg_s5, err_s5, v_s5;

	assign prod     = {phi_s4, MAG_HALF_W'(0)} + PROD_W'(plo_s4);
	assign prod_rnd = prod + (PROD_W'(1) << (LN_SHIFT - 1));
	assign ln_mag   = prod_rnd[PROD_W-1:LN_SHIFT];
	assign t0_ck    = Q30_DEN_W'(nominal_temp_c_q) * CENTI + ZERO_C_CENTI_K;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ln_num_s5  <= Q30_NUM_W'({ln_mag, BETA_W'(0)}) + Q30_NUM_W'(beta_kelvin_q >> 1);
			inv_num_s5 <= INV_T0_SCALE + Q30_NUM_W'(t0_ck >> 1);
			beta_s5    <= Q30_DEN_W'(beta_kelvin_q);
			t0_s5      <= t0_ck;
			neg_s5     <= neg_s4;
			err_s5     <= err_s4;
		end
	end

	logic                 term_valid, inv_valid, term_err, inv_neg;
	logic [Q30_NUM_W-1:0] term_mag, inv_t0;

	ntcbt_div_pipe #(.NUM_W(Q30_NUM_W), .DEN_W(Q30_DEN_W), .SIDE_W(1)) u_term_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s5),
		.num      (ln_num_s5),
		.den      (beta_s5),
		.side     (err_s5),
		.out_valid(term_valid),
		.quo      (term_mag),
		.out_side (term_err)
	);

	ntcbt_div_pipe #(.NUM_W(Q30_NUM_W), .DEN_W(Q30_DEN_W), .SIDE_W(1)) u_inv_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s5),
		.num      (inv_num_s5),
		.den      (t0_s5),
		.side     (neg_s5),
		.out_valid(inv_valid),
		.quo      (inv_t0),
		.out_side (inv_neg)
	);

	// s6: x = 1/T0 + ln/B, numerator of the final reciprocal
	logic signed [X_W-1:0] term, x;
	logic [TMK_NUM_W-1:0]  tmk_num_s6;
	logic [TMK_DEN_W-1:0]  x_s6;
	logic [1:0]            flags_s6;
	logic                  v_s6;

	assign term = inv_neg ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});
	assign x    = $signed({1'b0, inv_t0}) + term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= term_valid && inv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tmk_num_s6 <= TMK_SCALE + TMK_NUM_W'(x[TMK_DEN_W-1:1]);
			x_s6       <= x[TMK_DEN_W-1:0];
			flags_s6   <= {term_err, x[X_W-1] || (x == '0)};
		end
	end

	logic                 tmk_valid;
	logic [TMK_NUM_W-1:0] tmk;
	logic [1:0]           tmk_flags;

	ntcbt_div_pipe #(.NUM_W(TMK_NUM_W), .DEN_W(TMK_DEN_W), .SIDE_W(2)) u_tmk_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s6),
		.num      (tmk_num_s6),
		.den      (x_s6),
		.side     (flags_s6),
		.out_valid(tmk_valid),
		.quo      (tmk),
		.out_side (tmk_flags)
	);

	// s7: output register, kelvin to celsius and saturation
	temp_t temp_next;
	temp_t temp_q;
	logic  err_q;

	always_comb begin
		if (tmk_flags[1]) begin
			temp_next = '0;
		end else if (tmk_flags[0] || (tmk > TMK_HOT_LIMIT)) begin
			temp_next = TEMP_LIMIT;
		end else begin
			temp_next = tmk[TEMP_W-1:0] - ZERO_C_MILLI_K;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tmk_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temp_q <= temp_next;
			err_q  <= tmk_flags[1];
		end
	end

	assign out_valid           = out_valid_q;
	assign temperature_milli_c = temp_q;
	assign range_error         = err_q;

endmodule

### hw/rtl/ntcbt_checker.sv
// ----------------------------------------------------------------------------
// ntcbt_checker
// Port-level checks of the NTC temperature block, bound to the top level.
// ----------------------------------------------------------------------------
module ntcbt_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [ntcbt_pkg::TEMP_W-1:0] temperature_milli_c,
	input logic                                range_error
);

	// a result waiting at the output stays there
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(temperature_milli_c) && $stable(range_error))
		else $error("stalled result changed");

	// with no result held the input side must not stall
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> temperature_milli_c == '0)
		else $error("error result with nonzero temperature");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (temperature_milli_c <= 20'sd300000)
			&& (temperature_milli_c >= -20'sd300000))
		else $error("temperature outside saturation limits");

endmodule

bind ntc_beta_temperature ntcbt_checker u_checker (.*);

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks ntc_beta_temperature against a fixed-point beta-equation predictor
// over directed corner samples, several register settings and random traffic.
// ----------------------------------------------------------------------------
module testbench;
	import ntcbt_pkg::*;

	localparam int ADC_W = 12;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [ADC_W-1:0] adc_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [TEMP_W-1:0] temperature_milli_c;
	logic range_error;

	// predictor copy of the registers
	logic [DIV_W-1:0] div_ohms;
	logic [NOM_W-1:0] nom_ohms;
	logic [T0_W-1:0] nom_temp;
	logic [BETA_W-1:0] beta_k;
	logic [REF_W-1:0] ref_mv;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic err;
	} reading_t;

	reading_t pending_readings[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int results_seen = 0;
	int errors_seen = 0;
	int idle_cycles = 0;

	ntc_beta_temperature dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.adc_sample(adc_sample), .out_valid(out_valid), .out_stall(out_stall),
		.temperature_milli_c(temperature_milli_c), .range_error(range_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] log2_fix(logic [63:0] n);
		int k;
		logic [63:0] x;
		logic [63:0] frac;
		k = 0;
		frac = 0;
		while (k < 63 && (n >> (k + 1)) != 0)
			k++;
		if (k >= 30)
			x = n >> (k - 30);
		else
			x = n << (30 - k);
		for (int b = 29; b >= 0; b--) begin
			x = (x * x) >> 30;
			if (x >= 64'd1 << 31) begin
				x = x >> 1;
				frac[b] = 1'b1;
			end
		end
		return (64'(k) << 30) + frac;
	endfunction

	function automatic reading_t beta_temperature(logic [ADC_W-1:0] s);
		reading_t r;
		logic [63:0] vout, rt, mag, ln_mag, term_mag, t0_ck, inv_t0, tmk;
		longint diff, term, x, t;
		r.temp = '0;
		r.err = 1'b1;
		vout = (64'd3300 * s) >> ADC_W;
		if (vout == 0 || vout >= ref_mv || nom_ohms == 0 || beta_k == 0)
			return r;
		rt = (64'(div_ohms) * (ref_mv - vout)) / vout;
		if (rt == 0)
			return r;
		diff = longint'(log2_fix(64'(nom_ohms))) - longint'(log2_fix(rt));
		mag = diff < 0 ? 64'(-diff) : 64'(diff);
		ln_mag = (mag * 64'd11629080 + (64'd1 << 37)) >> 38;
		term_mag = ((ln_mag << 14) + beta_k / 2) / beta_k;
		term = diff < 0 ? -longint'(term_mag) : longint'(term_mag);
		t0_ck = 64'(nom_temp) * 100 + 27315;
		inv_t0 = ((64'd100 << 30) + t0_ck / 2) / t0_ck;
		x = longint'(inv_t0) + term;
		if (x <= 0) begin
			t = 300000;
		end else begin
			tmk = ((64'd1000 << 30) + 64'(x) / 2) / 64'(x);
			t = longint'(tmk) - 273150;
			if (t > 300000) t = 300000;
			if (t < -300000) t = -300000;
		end
		r.temp = TEMP_W'(t);
		r.err = 1'b0;
		return r;
	endfunction

	// valid stays up after a request so that the next one can follow at once
	task automatic send_sample(logic [ADC_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= s;
		pending_readings.push_back(beta_temperature(s));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// block is idle here, so writes go straight in
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_DIVIDER: div_ohms = val;
			REG_NOMINAL: nom_ohms = val;
			REG_NOM_TEMP: nom_temp = val[T0_W-1:0];
			REG_BETA: beta_k = val[BETA_W-1:0];
			REG_REFERENCE: ref_mv = val[REF_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_thermistor(int d, int n, int t0, int b, int r);
		write_reg(REG_DIVIDER, CFG_DATA_W'(d));
		write_reg(REG_NOMINAL, CFG_DATA_W'(n));
		write_reg(REG_NOM_TEMP, CFG_DATA_W'(t0));
		write_reg(REG_BETA, CFG_DATA_W'(b));
		write_reg(REG_REFERENCE, CFG_DATA_W'(r));
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed_corners();
		logic [ADC_W-1:0] corners[] = '{12'h000, 12'h001, 12'h002, 12'hFFF, 12'hFFE,
			12'h800, 12'h7FF, 12'h555, 12'hAAA, 12'd2048, 12'd4095, 12'd100,
			12'd3000, 12'd4000, 12'd1, 12'd5, 12'd3500, 12'd2800};
		foreach (corners[i]) send_sample(corners[i]);
	endtask

	task automatic test_register_extremes();
		// hot end beyond reach, cold saturation, zero registers, top values
		set_thermistor(1, 1000000, 0, 1, 5000);
		for (int i = 0; i < 12; i++) send_sample(ADC_W'($urandom));
		wait_drained();
		set_thermistor(1000000, 1, 150, 10000, 1);
		for (int i = 0; i < 12; i++) send_sample(ADC_W'($urandom));
		wait_drained();
		set_thermistor(1048575, 0, 255, 0, 8191);
		send_sample(12'd2048);
		send_sample(12'd100);
		wait_drained();
		write_reg(CFG_IDX_W'(7), 20'hFFFFF);
		set_thermistor(1, 1, 255, 16383, 5000);
		for (int i = 0; i < 12; i++) send_sample(ADC_W'($urandom));
		wait_drained();
		set_thermistor(9600, 10000, 25, 3950, 3300);
	endtask

	task automatic test_random_samples(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0)
				send_sample(ADC_W'($urandom_range(4095)));
			else
				send_sample(ADC_W'($urandom_range(3900, 150)));
		end
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 5; p++) begin
			wait_drained();
			set_thermistor($urandom_range(1000000, 1), $urandom_range(1000000, 1),
				$urandom_range(150), $urandom_range(10000, 1), $urandom_range(5000, 1));
			test_random_samples(40);
		end
		wait_drained();
		set_thermistor(9600, 10000, 25, 3950, 3300);
	endtask

	always @(posedge clk) begin
		if ($urandom_range(99) < recv_idle_pct)
			out_stall <= 1'b1;
		else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		reading_t want;
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (range_error) errors_seen++;
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result temp=%0d err=%0b", temperature_milli_c,
						range_error);
			end else begin
				want = pending_readings.pop_front();
				if (want.temp !== temperature_milli_c || want.err !== range_error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected temp=%0d err=%0b, got temp=%0d err=%0b",
							want.temp, want.err, temperature_milli_c, range_error);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no requests moving");
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		div_ohms = DIVIDER_RST;
		nom_ohms = NOMINAL_RST;
		nom_temp = NOM_TEMP_RST;
		beta_k = BETA_RST;
		ref_mv = REFERENCE_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		wait_drained();
		test_register_extremes();
		send_idle_pct = 15;
		recv_idle_pct = 87;
		test_random_samples(200);
		// hold off until the pipe has emptied
		wait_drained();
		send_idle_pct = 87;
		recv_idle_pct = 15;
		test_random_samples(200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_samples(200);
		test_random_settings();
		wait_drained();
		$display("covered %0d results (%0d range errors) over reset, extreme and random",
			results_seen, errors_seen);
		$display("register settings with three stall patterns");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
